>>> rtl/doubly_linked_list_engine_unit_assert.svh
// Assertion macros for the doubly linked list engine.
// Included by modules that carry concurrent assertions.
`ifndef DOUBLY_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define DLL_ASSERT_IMP(label, clk, rstn, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DLL_ASSERT_NXT(label, clk, rstn, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/dlle_pkg.sv
// Package for the doubly linked list engine: widths, mode codes and memory bundles.
// No dependencies.
package dlle_pkg;
    localparam int NODES = 256;
    localparam int IW = $clog2(NODES);
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] NIL = LW'(NODES);

    localparam logic [4:0] M_CLEAR = 5'd0;
    localparam logic [4:0] M_INS_FIRST = 5'd1;
    localparam logic [4:0] M_INS_LAST = 5'd2;
    localparam logic [4:0] M_CUR_FIRST = 5'd3;
    localparam logic [4:0] M_CUR_LAST = 5'd4;
    localparam logic [4:0] M_RD_FIRST = 5'd5;
    localparam logic [4:0] M_RD_LAST = 5'd6;
    localparam logic [4:0] M_DEL_FIRST = 5'd7;
    localparam logic [4:0] M_DEL_LAST = 5'd8;
    localparam logic [4:0] M_DEL_AFTER = 5'd9;
    localparam logic [4:0] M_DEL_BEFORE = 5'd10;
    localparam logic [4:0] M_INS_AFTER = 5'd11;
    localparam logic [4:0] M_INS_BEFORE = 5'd12;
    localparam logic [4:0] M_RD_CUR = 5'd13;
    localparam logic [4:0] M_WR_CUR = 5'd14;
    localparam logic [4:0] M_NEXT = 5'd15;
    localparam logic [4:0] M_PREV = 5'd16;
    localparam logic [4:0] M_QUERY = 5'd17;

    // Memory request bundle from the sequencer to the pool memory.
    typedef struct packed {
        logic [IW-1:0] raddr;
        logic          nwe;
        logic [IW-1:0] naddr;
        logic [LW-1:0] ndata;
        logic          pwe;
        logic [IW-1:0] paddr;
        logic [LW-1:0] pdata;
        logic          vwe;
        logic [IW-1:0] vaddr;
        logic [31:0]   vdata;
    } mem_req_t;

    typedef struct packed {
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
        logic [31:0]   val;
    } mem_rsp_t;
endpackage

>>> rtl/dlle_pool.sv
// Node pool: value, next and previous link memories with one read port.
// Depends on dlle_pkg.
module dlle_pool import dlle_pkg::*; (
    input  logic     aclk,
    input  mem_req_t req,
    output mem_rsp_t rsp
);
    logic [LW-1:0] next_mem [NODES];
    logic [LW-1:0] prev_mem [NODES];
    logic [31:0]   val_mem [NODES];

    always_ff @(posedge aclk) begin
        if (req.nwe) next_mem[req.naddr] <= req.ndata;
        if (req.pwe) prev_mem[req.paddr] <= req.pdata;
        if (req.vwe) val_mem[req.vaddr] <= req.vdata;
        rsp.nxt <= next_mem[req.raddr];
        rsp.prv <= prev_mem[req.raddr];
        rsp.val <= val_mem[req.raddr];
    end
endmodule

>>> rtl/doubly_linked_list_engine_unit.sv
// Doubly linked list engine with cursor, node pool in synchronous memories.
// Every mode walks the same states from input accept to result valid: R1
// reads the node under work, R3 reads the target node or the free head,
// the state after each read takes its links, then W and OUT write back.
// One word in flight at a time; the next is taken once the result is handed
// over.
// Reset (aresetn low, synchronous) empties the list and the free pool state.
`include "doubly_linked_list_engine_unit_assert.svh"
module doubly_linked_list_engine_unit import dlle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_mode,
    input  logic signed [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_read_value,
    output logic        m_error,
    output logic        m_active
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_R1 = 3'd1;
    localparam logic [2:0] ST_R2 = 3'd2;
    localparam logic [2:0] ST_R3 = 3'd3;
    localparam logic [2:0] ST_R4 = 3'd4;
    localparam logic [2:0] ST_W = 3'd5;
    localparam logic [2:0] ST_OUT = 3'd6;

    logic [2:0] st_reg, st_next;
    logic [4:0] mode_reg;
    logic [31:0] val_reg;
    logic [LW-1:0] head_reg, tail_reg, cur_reg, free_reg;
    logic [LW-1:0] fresh_reg;
    logic [LW-1:0] n_reg, t_reg, p_reg, q_reg;
    logic [31:0] rv_reg;
    logic err_reg;
    mem_req_t req;
    mem_rsp_t rsp;

    dlle_pool u_pool (.aclk(aclk), .req(req), .rsp(rsp));

    function automatic logic isn(input logic [LW-1:0] i);
        return i < NIL;
    endfunction
    function automatic logic [LW-1:0] cl(input logic [LW-1:0] i);
        return isn(i) ? i : NIL;
    endfunction

    assign s_ready = (st_reg == ST_IDLE) && !m_valid;

    logic is_ins, is_del, alloc_ok;
    assign is_ins = mode_reg == M_INS_FIRST || mode_reg == M_INS_LAST ||
                    mode_reg == M_INS_AFTER || mode_reg == M_INS_BEFORE;
    assign is_del = mode_reg == M_DEL_FIRST || mode_reg == M_DEL_LAST ||
                    mode_reg == M_DEL_AFTER || mode_reg == M_DEL_BEFORE;
    assign alloc_ok = isn(free_reg) || isn(fresh_reg);

    // Sequence: R1 reads the node under work (cursor, an end or the free
    // head), R2 picks the target node, R3 reads the target of deletes or the
    // free head of inserts, R4 latches those links, W and OUT write them back.
    always_comb begin
        req = '0;
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) st_next = ST_R1;
            end
            ST_R1: st_next = ST_R2;
            ST_R2: st_next = ST_R3;
            ST_R3: st_next = ST_R4;
            ST_R4: st_next = ST_W;
            ST_W: st_next = ST_OUT;
            ST_OUT: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
        // Read address selection.
        case (st_reg)
            ST_R1: req.raddr = t_reg[IW-1:0];
            ST_R3: req.raddr = is_del ? n_reg[IW-1:0] : free_reg[IW-1:0];
            default: req.raddr = '0;
        endcase
        if (st_reg == ST_W) begin
            if (is_ins && isn(n_reg)) begin
                req.vwe = 1'b1; req.vaddr = n_reg[IW-1:0]; req.vdata = val_reg;
                req.nwe = 1'b1; req.naddr = n_reg[IW-1:0]; req.ndata = q_reg;
                req.pwe = 1'b1; req.paddr = n_reg[IW-1:0]; req.pdata = p_reg;
            end else if (mode_reg == M_WR_CUR && isn(cur_reg)) begin
                req.vwe = 1'b1; req.vaddr = cur_reg[IW-1:0]; req.vdata = val_reg;
            end else if (is_del && isn(n_reg)) begin
                req.nwe = 1'b1; req.naddr = n_reg[IW-1:0]; req.ndata = free_reg;
                if (isn(q_reg)) begin
                    req.pwe = 1'b1; req.paddr = q_reg[IW-1:0]; req.pdata = p_reg;
                end
            end
        end
        if (st_reg == ST_OUT) begin
            // Second write port use: fix neighbor links of the change.
            if (is_ins && isn(n_reg)) begin
                if (isn(p_reg)) begin
                    req.nwe = 1'b1; req.naddr = p_reg[IW-1:0]; req.ndata = n_reg;
                end
                if (isn(q_reg)) begin
                    req.pwe = 1'b1; req.paddr = q_reg[IW-1:0]; req.pdata = n_reg;
                end
            end else if (is_del && isn(n_reg) && isn(p_reg)) begin
                req.nwe = 1'b1; req.naddr = p_reg[IW-1:0]; req.ndata = q_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            m_valid <= 1'b0;
            head_reg <= NIL; tail_reg <= NIL; cur_reg <= NIL;
            free_reg <= NIL; fresh_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        mode_reg <= s_mode;
                        val_reg <= s_value;
                        rv_reg <= '0;
                        err_reg <= 1'b0;
                        n_reg <= NIL;
                        p_reg <= NIL;
                        q_reg <= NIL;
                        // t: node whose links are read first.
                        case (s_mode) inside
                            M_DEL_AFTER, M_DEL_BEFORE, M_INS_AFTER, M_INS_BEFORE,
                            M_RD_CUR, M_NEXT, M_PREV: t_reg <= cl(cur_reg);
                            M_DEL_LAST, M_RD_LAST: t_reg <= cl(tail_reg);
                            M_INS_FIRST, M_INS_LAST: t_reg <= cl(free_reg);
                            default: t_reg <= cl(head_reg);
                        endcase
                        if (!isn(head_reg) || !isn(tail_reg)) begin
                            head_reg <= NIL; tail_reg <= NIL;
                            if (s_mode == M_DEL_FIRST || s_mode == M_DEL_LAST ||
                                s_mode == M_RD_FIRST || s_mode == M_RD_LAST)
                                t_reg <= NIL;
                        end
                        if (!isn(cur_reg)) cur_reg <= NIL;
                    end
                end
                ST_R1: ;
                ST_R2: begin
                    // rsp holds links of t.
                    case (mode_reg) inside
                        M_CLEAR: begin
                            head_reg <= NIL; tail_reg <= NIL; cur_reg <= NIL;
                            free_reg <= NIL; fresh_reg <= '0;
                        end
                        M_CUR_FIRST: cur_reg <= head_reg;
                        M_CUR_LAST: cur_reg <= tail_reg;
                        M_RD_FIRST, M_RD_LAST: begin
                            if (!isn(head_reg)) err_reg <= 1'b1;
                            else rv_reg <= rsp.val;
                        end
                        M_RD_CUR: begin
                            if (!isn(cur_reg)) err_reg <= 1'b1;
                            else rv_reg <= rsp.val;
                        end
                        M_NEXT: if (isn(cur_reg)) cur_reg <= cl(rsp.nxt);
                        M_PREV: if (isn(cur_reg)) cur_reg <= cl(rsp.prv);
                        M_DEL_FIRST, M_DEL_LAST: n_reg <= t_reg;
                        M_DEL_AFTER: if (isn(cur_reg)) n_reg <= cl(rsp.nxt);
                        M_DEL_BEFORE: if (isn(cur_reg)) n_reg <= cl(rsp.prv);
                        M_INS_FIRST, M_INS_LAST, M_INS_AFTER, M_INS_BEFORE: begin
                            if ((mode_reg == M_INS_AFTER || mode_reg == M_INS_BEFORE)
                                && !isn(cur_reg)) begin
                                n_reg <= NIL;
                            end else if (!alloc_ok) begin
                                err_reg <= 1'b1;
                            end else begin
                                if (isn(free_reg)) begin
                                    n_reg <= free_reg;
                                end else begin
                                    n_reg <= fresh_reg;
                                    fresh_reg <= fresh_reg + LW'(1);
                                end
                                unique case (mode_reg)
                                    M_INS_FIRST: begin
                                        p_reg <= NIL; q_reg <= head_reg;
                                    end
                                    M_INS_LAST: begin
                                        p_reg <= tail_reg; q_reg <= NIL;
                                    end
                                    M_INS_AFTER: begin
                                        p_reg <= cur_reg; q_reg <= cl(rsp.nxt);
                                    end
                                    default: begin
                                        p_reg <= cl(rsp.prv); q_reg <= cur_reg;
                                    end
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
                ST_R3: ;
                ST_R4: begin
                    // rsp holds links of the node read in R3: the free head for
                    // inserts, the node to remove for deletes.
                    if (is_ins && isn(n_reg) && isn(free_reg) && n_reg == free_reg) begin
                        free_reg <= cl(rsp.nxt);
                    end
                    if (is_del && isn(n_reg)) begin
                        p_reg <= cl(rsp.prv);
                        q_reg <= cl(rsp.nxt);
                    end
                end
                ST_W: begin
                    if (is_ins && isn(n_reg)) begin
                        if (!isn(p_reg)) head_reg <= n_reg;
                        if (!isn(q_reg)) tail_reg <= n_reg;
                    end
                    if (is_del && isn(n_reg)) begin
                        if (!isn(p_reg)) head_reg <= q_reg;
                        if (!isn(q_reg)) tail_reg <= p_reg;
                        if (cur_reg == n_reg) cur_reg <= NIL;
                        free_reg <= n_reg;
                    end
                end
                ST_OUT: begin
                    m_valid <= 1'b1;
                    m_read_value <= rv_reg;
                    m_error <= err_reg;
                    m_active <= isn(cur_reg);
                end
                default: ;
            endcase
        end
    end

    `DLL_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, st_reg != ST_IDLE, !s_ready)
    `DLL_ASSERT_NXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, st_reg == ST_R1)
    `DLL_ASSERT_NXT(a_out_sets_valid, aclk, aresetn, st_reg == ST_OUT, m_valid)
endmodule
